>>> sv/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants, types and helpers for the separable gaussian blur block.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int MAX_TAPS   = 15;
  localparam int HIST       = MAX_TAPS - 1;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COEF_BITS  = 16;

  localparam int TAP_W   = 4;
  localparam int POS_W   = 10;
  localparam int DIM_W   = 11;
  localparam int ADDR_W  = 14;
  localparam int ACC_W   = 36;
  localparam int MID_W   = 48;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  localparam int ROW_SHIFT = COEF_BITS - 8;
  localparam int COL_SHIFT = COEF_BITS + 8;

  localparam logic [IDX_W-1:0] REG_KERNEL_HALF  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_NEAR    = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_FAR     = 3'd4;

  typedef struct packed {
    logic             accept;
    logic             acc_clr;
    logic             row_mac;
    logic             mid_load;
    logic             col_rd;
    logic             col_mac_mem;
    logic             col_mac_mid;
    logic             out_load;
    logic             commit;
    logic [TAP_W-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic             do_row;
    logic             do_col;
    logic [TAP_W-1:0] tap_last;
  } stat_t;

  function automatic logic [COEF_BITS-1:0] tap_coef(input logic [TAP_W-1:0] t,
                                                    input logic [2:0] kh,
                                                    input logic [CFG_W-1:0] cn,
                                                    input logic [CFG_W-1:0] cf);
    logic [TAP_W-1:0] off;
    logic [CFG_W-1:0] w;
    off = (t >= {1'b0, kh}) ? t - {1'b0, kh} : {1'b0, kh} - t;
    w   = off[2] ? cf : cn;
    return w[off[1:0]*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

>>> sv/sgb_ctrl.sv
// ----------------------------------------------------------------------------
// sgb_ctrl
// Sequencer: steps the row taps, the column taps and the output hand-off.
// ----------------------------------------------------------------------------
module sgb_ctrl
  import sgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_MID   = 3'd2;
  localparam logic [2:0] S_CRD   = 3'd3;
  localparam logic [2:0] S_CMAC  = 3'd4;
  localparam logic [2:0] S_CLAST = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_UPD   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept  = 1'b1;
          cmd.acc_clr = 1'b1;
          tap_nxt     = '0;
          state_nxt   = stat.do_row ? S_ROW : S_UPD;
        end
      end
      S_ROW: begin
        cmd.row_mac = 1'b1;
        if (tap_r == stat.tap_last) begin
          state_nxt = S_MID;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      S_MID: begin
        cmd.mid_load = 1'b1;
        cmd.acc_clr  = 1'b1;
        tap_nxt      = '0;
        if (!stat.do_col) begin
          state_nxt = S_UPD;
        end else if (stat.tap_last == '0) begin
          state_nxt = S_CLAST;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        cmd.col_rd = 1'b1;
        state_nxt  = S_CMAC;
      end
      S_CMAC: begin
        cmd.col_mac_mem = 1'b1;
        tap_nxt         = tap_r + 1'b1;
        state_nxt       = (tap_r == stat.tap_last - 1'b1) ? S_CLAST : S_CRD;
      end
      S_CLAST: begin
        cmd.col_mac_mid = 1'b1;
        cmd.tap         = stat.tap_last;
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_UPD;
        end
      end
      S_UPD: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ov_nxt    = (ov_r && !out_ready) || cmd.out_load;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

>>> sv/sgb_datapath.sv
// ----------------------------------------------------------------------------
// sgb_datapath
// Registers, row window, line store and the three channel accumulators.
// ----------------------------------------------------------------------------
module sgb_datapath
  import sgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic [POS_W-1:0] out_column,
  output logic [POS_W-1:0] out_row,
  output logic             out_frame_last
);

  logic [2:0]       kh_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [CFG_W-1:0] cn_r, cf_r;
  logic [POS_W-1:0] col_r, row_r;
  logic [TAP_W-1:0] slot_r;
  logic [23:0]      win_r [HIST];
  logic [23:0]      px_r;
  logic [ACC_W-1:0] acc_r [3];
  logic [MID_W-1:0] mid_r, rdata_r;
  logic [7:0]       ch_out_r [3];
  logic [POS_W-1:0] ocol_r, orow_r;
  logic             olast_r;

  logic [MID_W-1:0] mem [HIST*MAX_WIDTH];

  logic [DIM_W-1:0] w_eff, h_eff, col_inc, row_inc;
  logic [TAP_W-1:0] kl, k, pidx, back, rslot;
  logic [POS_W-1:0] anchor;
  logic [23:0]      pix;
  logic [COEF_BITS-1:0] coef;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [MID_W-1:0] mid_nxt;
  logic             last_px;

  assign w_eff = (width_r == '0) ? DIM_W'(1) :
                 (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? DIM_W'(1) :
                 (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;

  assign kl      = {kh_r, 1'b0};
  assign k       = kl + 1'b1;
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign anchor  = col_r + POS_W'(1) - POS_W'(k);

  assign stat.do_row   = col_inc >= DIM_W'(k);
  assign stat.do_col   = row_inc >= DIM_W'(k);
  assign stat.tap_last = kl;

  assign coef = tap_coef(cmd.tap, kh_r, cn_r, cf_r);

  // tap k-1 is the current pixel, earlier taps come from the window
  assign pidx    = kl - 1'b1 - cmd.tap;
  assign last_px = (cmd.tap == kl);
  assign pix     = last_px ? px_r : win_r[pidx];

  assign back  = kl - cmd.tap;
  assign rslot = (slot_r >= back) ? slot_r - back : slot_r + TAP_W'(HIST) - back;
  assign raddr = {rslot, anchor};
  assign waddr = {slot_r, anchor};

  always_comb begin
    logic [ACC_W-1:0] v;
    mid_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      v = acc_r[c] >> ROW_SHIFT;
      mid_nxt[c*16 +: 16] = (v > ACC_W'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r     <= 3'd1;
      width_r  <= DIM_W'(512);
      height_r <= DIM_W'(512);
      cn_r     <= '0;
      cf_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_HALF:  kh_r     <= cfg_data[2:0];
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_COEF_NEAR:    cn_r     <= cfg_data;
        REG_COEF_FAR:     cf_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // position counters and row window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      for (int i = 0; i < HIST; i++) win_r[i] <= '0;
    end else if (cmd.commit) begin
      win_r[0] <= px_r;
      for (int i = 1; i < HIST; i++) win_r[i] <= win_r[i-1];
      if (col_inc >= w_eff) begin
        col_r <= '0;
        if (row_inc >= h_eff) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_inc[POS_W-1:0];
          slot_r <= (slot_r == TAP_W'(HIST-1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        col_r <= col_inc[POS_W-1:0];
        if ({1'b0, row_r} >= h_eff) begin
          row_r  <= '0;
          slot_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && stat.do_row) mem[waddr] <= mid_r;
    if (cmd.col_rd) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) px_r <= {in_blue_in, in_green_in, in_red_in};
    if (cmd.mid_load) mid_r <= mid_nxt;
    for (int c = 0; c < 3; c++) begin
      if (cmd.acc_clr) begin
        acc_r[c] <= '0;
      end else if (cmd.row_mac) begin
        acc_r[c] <= acc_r[c] + ACC_W'({16'd0, coef} * {24'd0, pix[c*8 +: 8]});
      end else if (cmd.col_mac_mem) begin
        acc_r[c] <= acc_r[c] + ACC_W'({16'd0, coef} * {16'd0, rdata_r[c*16 +: 16]});
      end else if (cmd.col_mac_mid) begin
        acc_r[c] <= acc_r[c] + ACC_W'({16'd0, coef} * {16'd0, mid_r[c*16 +: 16]});
      end
    end
    if (cmd.out_load) begin
      for (int c = 0; c < 3; c++) begin
        ch_out_r[c] <= ((acc_r[c] >> COL_SHIFT) > ACC_W'(255)) ? 8'hFF :
                       acc_r[c][COL_SHIFT +: 8];
      end
      ocol_r  <= anchor;
      orow_r  <= row_r + POS_W'(1) - POS_W'(k);
      olast_r <= (col_inc >= w_eff) && (row_inc >= h_eff);
    end
  end

  assign out_red_out    = ch_out_r[0];
  assign out_green_out  = ch_out_r[1];
  assign out_blue_out   = ch_out_r[2];
  assign out_column     = ocol_r;
  assign out_row        = orow_r;
  assign out_frame_last = olast_r;

endmodule

>>> sv/separable_gaussian_blur_rgb.sv
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb
// Top level: separable RGB blur over a raster pixel stream.
// ----------------------------------------------------------------------------
// One pixel is processed at a time. A pixel whose row window is incomplete
// is only committed; one that completes a row window also steps the row
// taps, and one that also completes a column window the column taps
// (k = 2*kernel_half+1 each), on the single shared multiply-accumulate per
// channel, with one registered read on the line store's single read port
// per column tap but the last, which takes the row result. Results sit in
// an output register so the next pixel is taken while a result waits; a
// new result that finds that register still full waits in its final step
// until the old one is taken. Coefficients are Q0.16, written by software.
module separable_gaussian_blur_rgb
  import sgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_red_in,
  input  logic [7:0]       in_green_in,
  input  logic [7:0]       in_blue_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic [POS_W-1:0] out_column,
  output logic [POS_W-1:0] out_row,
  output logic             out_frame_last
);

  cmd_t  cmd;
  stat_t stat;

  sgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgb_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .cmd            (cmd),
    .stat           (stat),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_frame_last (out_frame_last)
  );

endmodule
